[src/hri_pkg.sv]
// Shared types and constants for the Halton radical inverse block.
// Used by halton_radical_inverse and its testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hri_pkg;

	localparam int unsigned RADIX_W = 8;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC_R,
		ST_ACC_P,
		ST_FIN,
		ST_OUT
	} hri_state_t;

endpackage

`default_nettype wire

[src/hri_div_step.sv]
// One restoring divide step: shift one dividend bit into the partial
// remainder, compare against the divisor and subtract. Standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module hri_div_step #(
	parameter int unsigned WIDTH = 39
) (
	input  wire logic [WIDTH-1:0] rem_in,
	input  wire logic             bit_in,
	input  wire logic [WIDTH-1:0] divisor,
	output logic      [WIDTH-1:0] rem_out,
	output logic                  q_bit
);

	logic [WIDTH:0] shifted;
	logic [WIDTH:0] diff;

	always_comb begin
		shifted = {rem_in, bit_in};
		diff    = shifted - {1'b0, divisor};
		q_bit   = (shifted >= {1'b0, divisor});
		// remainder after the step is below the divisor, so the top bit is always zero
		rem_out = q_bit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	end

endmodule

`default_nettype wire

[src/halton_radical_inverse.sv]
// Per base-b digit of the index: a divide pass (ST_DIV), then ST_ACC_R and ST_ACC_P; then
// the final division (ST_FIN) and ST_OUT give the result. Index zero goes straight to ST_FIN.
// One index at a time: a new index is taken only in ST_IDLE, once the previous result has moved
// into the output register; ST_OUT waits while an unaccepted result still holds that register.
// Reset: arst_n asynchronous, clears control and sets radix to 2.
// Top level; uses hri_pkg and hri_div_step.
`timescale 1ns / 1ps
`default_nettype none

module halton_radical_inverse #(
	parameter int unsigned INDEX_WIDTH = 31,
	parameter int unsigned FRAC_WIDTH  = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [hri_pkg::RADIX_W-1:0]         cfg_wdata,   // radix
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((INDEX_WIDTH+7)/8)*8-1:0]    s_tdata,     // sample_index, zero pad
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [((FRAC_WIDTH+7)/8)*8-1:0]     m_tdata      // fraction, zero pad
);

	localparam int unsigned RW       = hri_pkg::RADIX_W;
	localparam int unsigned PW       = INDEX_WIDTH + RW;
	localparam int unsigned OUT_TW   = ((FRAC_WIDTH + 7) / 8) * 8;
	localparam int unsigned STEP_MAX = (INDEX_WIDTH > FRAC_WIDTH) ? INDEX_WIDTH : FRAC_WIDTH;
	localparam int unsigned CW       = $clog2(STEP_MAX);

	hri_pkg::hri_state_t state_q, state_d;

	logic [RW-1:0]          radix_q;
	logic [RW-1:0]          b_q;
	logic [INDEX_WIDTH-1:0] idx_q;
	logic [PW-1:0]          rem_q;
	logic [PW-1:0]          r_q;
	logic [PW-1:0]          p_q;
	logic [FRAC_WIDTH-1:0]  frac_q;
	logic [FRAC_WIDTH-1:0]  m_frac_q;
	logic                   m_valid_q;
	logic [CW-1:0]          cnt_q;

	logic [INDEX_WIDTH-1:0] in_idx;
	logic                   in_beat;
	logic                   out_free;
	logic                   div_bit;
	logic [PW-1:0]          div_divisor;
	logic [PW-1:0]          div_rem;
	logic                   div_q;
	logic [PW-1:0]          mul_a;
	logic [PW+RW-1:0]       prod;
	logic [PW-1:0]          mac;

	assign in_idx   = s_tdata[INDEX_WIDTH-1:0];
	assign s_tready = (state_q == hri_pkg::ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TW'(m_frac_q);

	// Shared divide step: digit extraction divides the index by b,
	// the final pass divides R * 2^FRAC_WIDTH by P = b^n.
	assign div_bit     = (state_q == hri_pkg::ST_DIV) ? idx_q[INDEX_WIDTH-1] : 1'b0;
	assign div_divisor = (state_q == hri_pkg::ST_DIV) ? PW'(b_q) : p_q;

	hri_div_step #(
		.WIDTH(PW)
	) u_div_step (
		.rem_in (rem_q),
		.bit_in (div_bit),
		.divisor(div_divisor),
		.rem_out(div_rem),
		.q_bit  (div_q)
	);

	// Small multiplier shared between the reversed-digit accumulator and the power of b
	assign mul_a = (state_q == hri_pkg::ST_ACC_R) ? r_q : p_q;
	assign prod  = (PW+RW)'(mul_a) * (PW+RW)'(b_q);
	assign mac   = prod[PW-1:0] + ((state_q == hri_pkg::ST_ACC_R) ? rem_q : '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hri_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = (in_idx == '0) ? hri_pkg::ST_FIN : hri_pkg::ST_DIV;
				end
			end
			hri_pkg::ST_DIV: begin
				if (cnt_q == CW'(INDEX_WIDTH - 1)) begin
					state_d = hri_pkg::ST_ACC_R;
				end
			end
			hri_pkg::ST_ACC_R: begin
				state_d = hri_pkg::ST_ACC_P;
			end
			hri_pkg::ST_ACC_P: begin
				state_d = (idx_q == '0) ? hri_pkg::ST_FIN : hri_pkg::ST_DIV;
			end
			hri_pkg::ST_FIN: begin
				if (cnt_q == CW'(FRAC_WIDTH - 1)) begin
					state_d = hri_pkg::ST_OUT;
				end
			end
			hri_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = hri_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hri_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hri_pkg::ST_IDLE;
			radix_q   <= hri_pkg::RADIX_RESET;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if ((state_q == hri_pkg::ST_DIV || state_q == hri_pkg::ST_FIN)
					&& state_d == state_q) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == hri_pkg::ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hri_pkg::ST_IDLE: begin
				if (in_beat) begin
					idx_q <= in_idx;
					r_q   <= '0;
					p_q   <= PW'(1);
					rem_q <= '0;
					b_q   <= (radix_q < hri_pkg::RADIX_MIN) ? hri_pkg::RADIX_MIN : radix_q;
				end
			end
			hri_pkg::ST_DIV: begin
				// quotient bits shift in behind the dividend bits
				idx_q <= {idx_q[INDEX_WIDTH-2:0], div_q};
				rem_q <= div_rem;
			end
			hri_pkg::ST_ACC_R: begin
				r_q <= mac;
			end
			hri_pkg::ST_ACC_P: begin
				p_q   <= mac;
				// once the index is exhausted, start the final division with R as partial remainder, else clear it
				rem_q <= (idx_q == '0) ? r_q : '0;
			end
			hri_pkg::ST_FIN: begin
				rem_q  <= div_rem;
				frac_q <= {frac_q[FRAC_WIDTH-2:0], div_q};
			end
			hri_pkg::ST_OUT: begin
				if (out_free) begin
					m_frac_q <= frac_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hri_pkg::ST_ACC_R) |-> (rem_q < PW'(b_q)))
		else $error("digit not below base");

	a_rem_below_pow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hri_pkg::ST_FIN) |-> (rem_q < p_q))
		else $error("partial remainder not below b^n");

	a_base_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != hri_pkg::ST_IDLE) |-> (b_q >= hri_pkg::RADIX_MIN))
		else $error("working base below two");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q != hri_pkg::ST_IDLE))
		else $error("accepted beat did not start work");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_halton_radical_inverse.sv]
// Testbench for halton_radical_inverse: streams sample indexes under several radix settings
// and checks every fraction against an exact in-bench radical inverse predictor.
// Depends on hri_pkg and the halton_radical_inverse RTL only.
`timescale 1ns / 1ps

module tb_halton_radical_inverse;

	localparam int unsigned INDEX_WIDTH = 31;
	localparam int unsigned FRAC_WIDTH  = 32;
	localparam int unsigned IN_BYTES_W  = ((INDEX_WIDTH + 7) / 8) * 8;
	localparam int unsigned OUT_BYTES_W = ((FRAC_WIDTH + 7) / 8) * 8;
	localparam int unsigned PHASES      = 9;
	localparam int unsigned PHASE_ITEMS = 89;
	localparam int unsigned HOLD_CYCLES = 2000;

	// Exact predictor plus the queue of fractions still owed by the block.
	class radical_inverse_board;
		logic [hri_pkg::RADIX_W-1:0] radix_reg;
		logic [FRAC_WIDTH-1:0]       expected_fractions[$];
		int unsigned                 fails;

		function new();
			radix_reg = hri_pkg::RADIX_RESET;
			fails = 0;
		endfunction

		function void set_radix(logic [hri_pkg::RADIX_W-1:0] value);
			radix_reg = value;
		endfunction

		function logic [FRAC_WIDTH-1:0] radical_inverse(logic [INDEX_WIDTH-1:0] sample);
			longint unsigned base_b;
			longint unsigned rest;
			longint unsigned acc;
			int unsigned     digits[$];
			base_b = (radix_reg < hri_pkg::RADIX_MIN) ? longint'(hri_pkg::RADIX_MIN)
				: longint'(radix_reg);
			rest = sample;
			acc = 0;
			while (rest != 0) begin
				digits.push_back(int'(rest % base_b));
				rest = rest / base_b;
			end
			// fold from the most significant digit down; the floor at each stage is exact
			while (digits.size() != 0)
				acc = ((longint'(digits.pop_back()) << FRAC_WIDTH) + acc) / base_b;
			return acc[FRAC_WIDTH-1:0];
		endfunction

		function void note_index(logic [IN_BYTES_W-1:0] beat);
			expected_fractions.push_back(radical_inverse(beat[INDEX_WIDTH-1:0]));
		endfunction

		function void check_fraction(logic [OUT_BYTES_W-1:0] beat);
			logic [FRAC_WIDTH-1:0] want;
			if (expected_fractions.size() == 0) begin
				$error("fraction: unexpected beat %h with nothing pending", beat);
				fails++;
				return;
			end
			want = expected_fractions.pop_front();
			if (beat[FRAC_WIDTH-1:0] !== want) begin
				$error("fraction mismatch: expected %h, actual %h", want, beat[FRAC_WIDTH-1:0]);
				fails++;
			end
		endfunction

		function int unsigned pending();
			return expected_fractions.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [hri_pkg::RADIX_W-1:0]   cfg_wdata = '0;
	logic                          s_tvalid = 1'b0;
	wire                           s_tready;
	logic [IN_BYTES_W-1:0]         s_tdata = '0;      // sample_index, zero pad
	wire                           m_tvalid;
	logic                          m_tready = 1'b0;
	wire  [OUT_BYTES_W-1:0]        m_tdata;           // fraction, zero pad

	radical_inverse_board board = new();
	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 50;
	bit          hold_req = 1'b0;

	halton_radical_inverse #(
		.INDEX_WIDTH(INDEX_WIDTH),
		.FRAC_WIDTH (FRAC_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: check each accepted beat, then pick tready for the next edge.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_fraction(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_index(input logic [IN_BYTES_W-1:0] beat);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_index(beat);
	endtask

	// Drop valid and wait until the block has returned everything it owes.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radix(input logic [hri_pkg::RADIX_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_radix(value);
	endtask

	// Mostly short indexes keep base-2 runs cheap; a quarter span all 31 bits.
	function automatic logic [IN_BYTES_W-1:0] pick_index();
		logic [IN_BYTES_W-1:0] sample;
		int unsigned           nbits;
		sample = '0;
		if ($urandom_range(0, 3) == 0) begin
			sample[INDEX_WIDTH-1:0] = INDEX_WIDTH'($urandom);
		end else begin
			nbits = $urandom_range(1, INDEX_WIDTH);
			sample[INDEX_WIDTH-1:0] = INDEX_WIDTH'($urandom & ((32'd1 << nbits) - 1));
		end
		return sample;
	endfunction

	initial begin
		logic [IN_BYTES_W-1:0]       pad_bit;
		logic [IN_BYTES_W-1:0]       max_index;
		logic [hri_pkg::RADIX_W-1:0] phase_radix[PHASES];

		pad_bit = '0;
		pad_bit[IN_BYTES_W-1] = 1'b1;
		max_index = '0;
		max_index[INDEX_WIDTH-1:0] = '1;
		phase_radix = '{8'd3, 8'd255, 8'd2, 8'd0, 8'd7, 8'($urandom_range(2, 255)),
			8'd1, 8'd16, 8'($urandom_range(2, 255))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radix is base 2
		send_index('0);
		send_index(32'd1);
		send_index(32'd2);
		send_index(32'd3);
		send_index(max_index);
		send_index(32'h4000_0000);
		send_index(32'h5555_5555 & max_index);
		send_index(32'h2AAA_AAAA);
		send_index(pad_bit);
		send_index(pad_bit | 32'd6);
		drain();

		// radix zero and one fall back to base 2
		write_radix(8'd0);
		send_index(32'd1);
		send_index(max_index);
		send_index(32'd5);
		drain();
		write_radix(8'd1);
		send_index(32'd6);
		send_index(max_index);
		drain();

		write_radix(8'd255);
		send_index(32'd254);
		send_index(32'd255);
		send_index(32'd256);
		send_index(max_index);
		send_index('0);
		drain();
		write_radix(8'd3);
		send_index(32'd8);
		send_index(max_index);
		drain();

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_radix(phase_radix[p]);
			for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
				// long result-side stall while input keeps coming
				if (p == 1 && k == 20)
					hold_req = 1'b1;
				send_index(pick_index());
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (board.fails == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (board.pending() != 0)
				$error("fraction: %0d expected beats never arrived", board.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[halton_radical_inverse.f]
src/hri_pkg.sv
src/hri_div_step.sv
src/halton_radical_inverse.sv
tb/sv/tb_halton_radical_inverse.sv
